### rtl/core/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg: shared types and constants for the C token classifier
// Token class codes, keyword table, result and queue entry records.
// ----------------------------------------------------------------------------
package ctc_pkg;

   // limits
   localparam int MAX_WORD_LEN  = 255;
   localparam int IF_DEPTH_BITS = 16;
   localparam int LEN_W         = $clog2(MAX_WORD_LEN + 1);

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // token classes
   localparam logic [3:0] TC_SEP     = 4'd0;
   localparam logic [3:0] TC_OP      = 4'd1;
   localparam logic [3:0] TC_PAIR    = 4'd2;
   localparam logic [3:0] TC_BADPAIR = 4'd3;
   localparam logic [3:0] TC_KEYWORD = 4'd4;
   localparam logic [3:0] TC_NUMBER  = 4'd5;
   localparam logic [3:0] TC_IDENT   = 4'd6;
   localparam logic [3:0] TC_UNKNOWN = 4'd7;
   localparam logic [3:0] TC_EOL     = 4'd8;

   // number bases, also the index of each number recognizer
   localparam logic [1:0] NB_BIN = 2'd0;
   localparam logic [1:0] NB_OCT = 2'd1;
   localparam logic [1:0] NB_HEX = 2'd2;
   localparam logic [1:0] NB_DEC = 2'd3;
   localparam int NUM_BASES = 4;

   // keywords
   localparam int NUM_KW = 11;
   localparam logic [3:0] KW_IF   = 4'd5;
   localparam logic [3:0] KW_ELSE = 4'd6;

   localparam logic [0:NUM_KW-1][0:5][7:0] KW_TEXT = '{
      '{"v", "o", "i", "d", 8'd0, 8'd0},
      '{"i", "n", "t", 8'd0, 8'd0, 8'd0},
      '{"f", "l", "o", "a", "t", 8'd0},
      '{"c", "h", "a", "r", 8'd0, 8'd0},
      '{"f", "o", "r", 8'd0, 8'd0, 8'd0},
      '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0},
      '{"e", "l", "s", "e", 8'd0, 8'd0},
      '{"w", "h", "i", "l", "e", 8'd0},
      '{"r", "e", "t", "u", "r", "n"},
      '{"m", "a", "i", "n", 8'd0, 8'd0},
      '{"d", "o", "u", "b", "l", "e"}
   };
   localparam logic [0:NUM_KW-1][2:0] KW_LEN = '{
      3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6
   };

   // one result item
   typedef struct packed {
      logic [3:0] token_class;
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic [3:0] keyword_index;
      logic [1:0] number_base;
      logic [7:0] word_length;
      logic       else_without_if;
      logic       last_result;
   } result_type;

   // all results caused by one input item (one or two)
   typedef struct packed {
      logic       second;
      result_type r0;
      result_type r1;
   } entry_type;

endpackage

### rtl/core/ctc_front.sv
// ----------------------------------------------------------------------------
// ctc_front: lexer front end
// Takes one character per cycle while accept is high, runs the incremental keyword,
// identifier and number recognizers, and builds the one or two results of each item.
// ----------------------------------------------------------------------------
module ctc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   input  logic               end_of_text,
   output ctc_pkg::entry_type entry,
   output logic               entry_valid
);
   import ctc_pkg::*;

   // number recognizer states
   localparam logic [2:0] NS_START  = 3'd0;
   localparam logic [2:0] NS_ZERO   = 3'd1;
   localparam logic [2:0] NS_PREFIX = 3'd2;
   localparam logic [2:0] NS_INT    = 3'd3;
   localparam logic [2:0] NS_FRAC   = 3'd4;
   localparam logic [2:0] NS_DEAD   = 3'd7;

   localparam logic [7:0] CH_NL = 8'd10;

   function automatic logic is_op(input logic [7:0] c);
      return c == "+" || c == "-" || c == "/" || c == "*" || c == "%" ||
             c == "=" || c == ">" || c == "!" || c == "<";
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == " " || c == "," || c == ";" || c == "(" || c == ")" ||
             c == "[" || c == "]" || c == "{" || c == "}";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic pair_ok(input logic [7:0] a, input logic [7:0] b);
      logic ok;
      if (b == "=") begin
         ok = a == "=" || a == "+" || a == "-" || a == "*" || a == "/" ||
              a == "%" || a == "<" || a == ">" || a == "!";
      end else begin
         ok = (a == "+" && b == "+") || (a == "-" && b == "-");
      end
      return ok;
   endfunction

   // one step of the number recognizer for one base
   function automatic logic [2:0] num_next(input logic [1:0] kind, input logic [2:0] st,
                                           input logic [7:0] c);
      logic       d;
      logic [2:0] nx;
      unique case (kind)
         NB_BIN:  d = c == "0" || c == "1";
         NB_OCT:  d = c >= "0" && c <= "7";
         NB_HEX:  d = is_digit(c) || (c >= "A" && c <= "F");
         default: d = is_digit(c);
      endcase
      nx = NS_DEAD;
      unique case (st)
         NS_START: begin
            if (kind == NB_DEC) nx = d ? NS_INT : (c == "." ? NS_FRAC : NS_DEAD);
            else                nx = (c == "0") ? NS_ZERO : NS_DEAD;
         end
         NS_ZERO: begin
            if (kind == NB_OCT)      nx = d ? NS_INT : (c == "." ? NS_FRAC : NS_DEAD);
            else if (kind == NB_BIN) nx = (c == "b") ? NS_PREFIX : NS_DEAD;
            else if (kind == NB_HEX) nx = (c == "x" || c == "X") ? NS_PREFIX : NS_DEAD;
            else                     nx = NS_DEAD;
         end
         NS_PREFIX, NS_INT: nx = d ? NS_INT : (c == "." ? NS_FRAC : NS_DEAD);
         NS_FRAC:           nx = d ? NS_FRAC : NS_DEAD;
         default:           nx = NS_DEAD;
      endcase
      return nx;
   endfunction

   function automatic result_type char_res(input logic [3:0] cls, input logic [7:0] c);
      result_type r;
      r             = '0;
      r.token_class = cls;
      r.first_char  = c;
      return r;
   endfunction

   // lexer state
   logic                          word_active_ff, word_active_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [NUM_KW-1:0]             kw_alive_ff, kw_alive_in;
   logic                          ident_ff, ident_in;
   logic [NUM_BASES-1:0][2:0]     dfa_ff, dfa_in;
   logic [7:0]                    pend_char_ff, pend_char_in;
   logic                          pend_ff, pend_in;
   logic [IF_DEPTH_BITS-1:0]      depth_ff, depth_in;

   // state after taking the current character into the word
   logic [NUM_KW-1:0]             kw_fed;
   logic                          ident_fed;
   logic [NUM_BASES-1:0][2:0]     dfa_fed;
   logic [LEN_W-1:0]              len_fed;

   // word classifier inputs and outputs
   logic                          c_op, c_sep, c_nl, c_word;
   logic [NUM_KW-1:0]             cl_alive;
   logic                          cl_ident;
   logic [NUM_BASES-1:0][2:0]     cl_dfa;
   logic [LEN_W-1:0]              cl_len;
   logic                          kw_hit, num_hit;
   logic [3:0]                    kw_idx;
   logic [1:0]                    num_idx;
   result_type                    w_res;
   logic                          w_emit;

   // result slots before packing
   logic                          x_valid, y_valid;
   result_type                    x_res, y_res;

   // character kind
   always_comb begin
      c_op   = is_op(ch);
      c_sep  = is_sep(ch);
      c_nl   = ch == CH_NL;
      c_word = !c_op && !c_sep && !c_nl;
   end

   // recognizers advanced by one character
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         kw_fed[k] = kw_alive_ff[k] && (32'(len_ff) < 32'(KW_LEN[k])) &&
                     (KW_TEXT[k][len_ff[2:0]] == ch);
      end
      if (len_ff == '0) ident_fed = is_alpha(ch) || ch == "_";
      else              ident_fed = ident_ff && (is_alpha(ch) || is_digit(ch) || ch == "_");
      for (int k = 0; k < NUM_BASES; k++) begin
         dfa_fed[k] = num_next(2'(k), dfa_ff[k], ch);
      end
      len_fed = (32'(len_ff) < MAX_WORD_LEN) ? len_ff + 1'b1 : len_ff;
   end

   // word classifier: keyword, then number, then identifier or unknown
   always_comb begin
      cl_alive = c_word ? kw_fed : kw_alive_ff;
      cl_ident = c_word ? ident_fed : ident_ff;
      cl_dfa   = c_word ? dfa_fed : dfa_ff;
      cl_len   = c_word ? len_fed : len_ff;

      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (cl_alive[k] && 32'(cl_len) == 32'(KW_LEN[k])) begin
            kw_hit = 1'b1;
            kw_idx = 4'(k);
         end
      end
      num_hit = 1'b0;
      num_idx = '0;
      for (int k = NUM_BASES - 1; k >= 0; k--) begin
         if (cl_dfa[k] == NS_INT || cl_dfa[k] == NS_FRAC) begin
            num_hit = 1'b1;
            num_idx = 2'(k);
         end
      end

      w_res             = '0;
      w_res.word_length = (32'(cl_len) > 32'd255) ? 8'hFF : 8'(cl_len);
      if (kw_hit) begin
         w_res.token_class     = TC_KEYWORD;
         w_res.keyword_index   = kw_idx;
         w_res.else_without_if = (kw_idx == KW_ELSE) && (depth_ff == '0);
      end else if (num_hit) begin
         w_res.token_class = TC_NUMBER;
         w_res.number_base = num_idx;
      end else begin
         w_res.token_class = cl_ident ? TC_IDENT : TC_UNKNOWN;
      end
   end

   // result slots: x comes first, y second; at most one is a word
   always_comb begin
      x_valid = 1'b0;
      y_valid = 1'b0;
      x_res   = '0;
      y_res   = '0;
      w_emit  = 1'b0;
      priority if (c_op) begin
         if (pend_ff) begin
            x_valid             = 1'b1;
            x_res               = char_res(pair_ok(pend_char_ff, ch) ? TC_PAIR : TC_BADPAIR,
                                           pend_char_ff);
            x_res.second_char   = ch;
         end else begin
            x_valid = word_active_ff;
            x_res   = w_res;
            w_emit  = word_active_ff;
            y_valid = end_of_text;
            y_res   = char_res(TC_OP, ch);
         end
      end else if (c_sep || c_nl) begin
         x_valid = pend_ff || word_active_ff;
         x_res   = pend_ff ? char_res(TC_OP, pend_char_ff) : w_res;
         w_emit  = !pend_ff && word_active_ff;
         y_valid = 1'b1;
         y_res   = c_sep ? char_res(TC_SEP, ch) : char_res(TC_EOL, 8'd0);
      end else begin
         x_valid = pend_ff;
         x_res   = char_res(TC_OP, pend_char_ff);
         y_valid = end_of_text;
         y_res   = w_res;
         w_emit  = end_of_text;
      end
   end

   // pack the slots into one queue entry
   always_comb begin
      entry_valid          = x_valid || y_valid;
      entry.second         = x_valid && y_valid;
      entry.r0             = x_valid ? x_res : y_res;
      entry.r0.last_result = !(x_valid && y_valid);
      entry.r1             = y_res;
      entry.r1.last_result = 1'b1;
   end

   // next lexer state
   always_comb begin
      word_active_in = 1'b0;
      len_in         = '0;
      kw_alive_in    = '1;
      ident_in       = 1'b1;
      dfa_in         = '0;
      pend_in        = 1'b0;
      pend_char_in   = pend_char_ff;
      depth_in       = depth_ff;

      if (c_op && pend_ff) begin
         // word is idle while an operator is held
         word_active_in = word_active_ff;
         len_in         = len_ff;
         kw_alive_in    = kw_alive_ff;
         ident_in       = ident_ff;
         dfa_in         = dfa_ff;
      end else if (c_op) begin
         pend_in      = !end_of_text;
         pend_char_in = ch;
      end else if (c_word && !end_of_text) begin
         word_active_in = 1'b1;
         len_in         = len_fed;
         kw_alive_in    = kw_fed;
         ident_in       = ident_fed;
         dfa_in         = dfa_fed;
      end

      // if/else nesting
      if (w_emit && kw_hit) begin
         if (kw_idx == KW_IF && depth_ff != '1)        depth_in = depth_ff + 1'b1;
         else if (kw_idx == KW_ELSE && depth_ff != '0) depth_in = depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_active_ff <= 1'b0;
         len_ff         <= '0;
         kw_alive_ff    <= '1;
         ident_ff       <= 1'b1;
         dfa_ff         <= '0;
         pend_ff        <= 1'b0;
         depth_ff       <= '0;
      end else if (accept) begin
         word_active_ff <= word_active_in;
         len_ff         <= len_in;
         kw_alive_ff    <= kw_alive_in;
         ident_ff       <= ident_in;
         dfa_ff         <= dfa_in;
         pend_ff        <= pend_in;
         depth_ff       <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_char_ff <= pend_char_in;
      end
   end

   // a held operator always closed any open word first
   a_op_word_excl: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && word_active_ff))
      else $error("held operator and open word at once");

   // an open word has a nonzero length, a closed one is cleared
   a_len_tracks_word: assert property (@(posedge clock) disable iff (reset)
      word_active_ff == (len_ff != '0))
      else $error("word length out of step with word state");

endmodule

### rtl/core/ctc_queue.sv
// ----------------------------------------------------------------------------
// ctc_queue: entry queue between front and back
// Small register queue of result entries; lets front and back stall apart.
// ----------------------------------------------------------------------------
module ctc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ctc_pkg::entry_type push_entry,
   input  logic               pop,
   output ctc_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import ctc_pkg::*;

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      empty   = count_ff == '0;
      full    = count_ff == Q_CNT_W'(QUEUE_DEPTH);
      do_push = push && !full;
      do_pop  = pop && !empty;
      head    = slots_ff[rd_ptr_ff];
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("queue fill level beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || 32'(count_ff) == QUEUE_DEPTH) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill level");

endmodule

### rtl/core/ctc_back.sv
// ----------------------------------------------------------------------------
// ctc_back: result sequencer
// Splits each queue entry into its one or two result items and holds the
// current one in an output register until it is taken.
// ----------------------------------------------------------------------------
module ctc_back (
   input  logic                clock,
   input  logic                reset,
   input  ctc_pkg::entry_type  head,
   input  logic                q_empty,
   output logic                deq,
   input  logic                out_pop,
   output logic                out_empty,
   output ctc_pkg::result_type out_res
);
   import ctc_pkg::*;

   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   result_type res_ff;
   logic       load;

   // pull the next item whenever the output register frees up
   always_comb begin
      load     = (!valid_ff || out_pop) && !q_empty;
      deq      = load && (sel_ff || !head.second);
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = !deq;
         valid_in = 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= sel_ff ? head.r1 : head.r0;
      end
   end

   assign out_empty = !valid_ff;
   assign out_res   = res_ff;

   // the second half of an entry is only pending while that entry is queued
   a_sel_needs_head: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> !q_empty && head.second)
      else $error("second item pending without a two-item entry");

endmodule

### rtl/core/c_token_classifier.sv
// ----------------------------------------------------------------------------
// c_token_classifier: streaming C token classifier
// One source character per item in, token results out, up to two per item.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  request   req_ch, req_end_of_text      push / full
//  response  rsp_token_class ... last     empty / pop
//
//  An item is accepted every cycle while the four-entry queue has room; the
//  front end classifies it in that same cycle and queues its results.
//  Results leave one per cycle from the output register while the receiver
//  pops, so items that cause two results drain at half rate; the first result
//  of an item passes a queue slot and then the output register on its way out.
//  Synchronous reset clears the lexer state, the queue and the output stage.
// ----------------------------------------------------------------------------
module c_token_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [3:0] rsp_token_class,
   output logic [7:0] rsp_first_char,
   output logic [7:0] rsp_second_char,
   output logic [3:0] rsp_keyword_index,
   output logic [1:0] rsp_number_base,
   output logic [7:0] rsp_word_length,
   output logic       rsp_else_without_if,
   output logic       rsp_last_result
);
   import ctc_pkg::*;

   logic       accept;
   entry_type  fe_entry;
   logic       fe_valid;
   entry_type  q_head;
   logic       q_empty, q_full;
   logic       deq;
   result_type out_res;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ctc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_ch),
      .end_of_text (req_end_of_text),
      .entry       (fe_entry),
      .entry_valid (fe_valid)
   );

   ctc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && fe_valid),
      .push_entry (fe_entry),
      .pop        (deq),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   ctc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .deq       (deq),
      .out_pop   (rsp_pop),
      .out_empty (rsp_empty),
      .out_res   (out_res)
   );

   // result fields
   assign rsp_token_class     = out_res.token_class;
   assign rsp_first_char      = out_res.first_char;
   assign rsp_second_char     = out_res.second_char;
   assign rsp_keyword_index   = out_res.keyword_index;
   assign rsp_number_base     = out_res.number_base;
   assign rsp_word_length     = out_res.word_length;
   assign rsp_else_without_if = out_res.else_without_if;
   assign rsp_last_result     = out_res.last_result;

endmodule

### bench/tb_c_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_token_classifier: self-checking bench for the C token classifier
// Source bytes go in through the push/full queue port. A behavioral lexer
// inside the bench predicts the tokens of every accepted item. Each popped
// token is compared field by field with the oldest prediction. Stimulus is a
// short directed string, one over-long word, and three random C-like streams
// run under different sender and receiver idle rates.
// ----------------------------------------------------------------------------
module tb_c_token_classifier;
   import ctc_pkg::*;

   localparam int         CYCLE_LIMIT = 200_000;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         PRINT_CAP   = 60;
   localparam logic [7:0] LINE_FEED   = 8'd10;

   // number recognizer states
   localparam logic [2:0] NS_START  = 3'd0;
   localparam logic [2:0] NS_ZERO   = 3'd1;
   localparam logic [2:0] NS_PREFIX = 3'd2;
   localparam logic [2:0] NS_INT    = 3'd3;
   localparam logic [2:0] NS_FRAC   = 3'd4;
   localparam logic [2:0] NS_DEAD   = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_ch = 8'd0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [3:0] rsp_token_class;
   logic [7:0] rsp_first_char;
   logic [7:0] rsp_second_char;
   logic [3:0] rsp_keyword_index;
   logic [1:0] rsp_number_base;
   logic [7:0] rsp_word_length;
   logic       rsp_else_without_if;
   logic       rsp_last_result;

   c_token_classifier dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_ch              (req_ch),
      .req_end_of_text     (req_end_of_text),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_token_class     (rsp_token_class),
      .rsp_first_char      (rsp_first_char),
      .rsp_second_char     (rsp_second_char),
      .rsp_keyword_index   (rsp_keyword_index),
      .rsp_number_base     (rsp_number_base),
      .rsp_word_length     (rsp_word_length),
      .rsp_else_without_if (rsp_else_without_if),
      .rsp_last_result     (rsp_last_result)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench bookkeeping
   int error_count   = 0;
   int cycle_count   = 0;
   int chars_sent    = 0;
   int tokens_seen   = 0;
   int send_idle_pct = 21;
   int recv_idle_pct = 46;
   int eot_pct       = 0;

   string kw_spelling [NUM_KW] = '{"void", "int", "float", "char", "for", "if",
                                   "else", "while", "return", "main", "double"};
   string op_chars   = "+-/*%=><!";
   string sep_chars  = " ,;()[]{}";
   string good_pairs = "==++--+=-=*=/=%=<=>=!=";

   result_type expected_tokens [$];
   result_type item_tokens [$];

   // lexer state of the prediction
   logic                     word_open;
   int unsigned              word_len;
   logic [NUM_KW-1:0]        kw_live;
   logic                     ident_live;
   logic [2:0]               num_state [NUM_BASES];
   logic [7:0]               held_op;
   logic                     held_op_valid;
   logic [IF_DEPTH_BITS-1:0] open_ifs;

   // ------------------------------------------------------------------
   // character classes
   // ------------------------------------------------------------------
   function automatic bit is_separator(logic [7:0] c);
      return c inside {" ", ",", ";", "(", ")", "[", "]", "{", "}"};
   endfunction

   function automatic bit is_operator(logic [7:0] c);
      return c inside {"+", "-", "/", "*", "%", "=", ">", "!", "<"};
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit pair_valid(logic [7:0] a, logic [7:0] b);
      if (b == "=")
         return a inside {"=", "+", "-", "*", "/", "%", "<", ">", "!"};
      return (a == "+" && b == "+") || (a == "-" && b == "-");
   endfunction

   // one step of the number recognizer for one base
   function automatic logic [2:0] next_number_state(logic [1:0] nb, logic [2:0] st,
                                                    logic [7:0] c);
      bit dig;
      case (nb)
         NB_BIN:  dig = c inside {"0", "1"};
         NB_OCT:  dig = c >= "0" && c <= "7";
         NB_HEX:  dig = is_digit(c) || (c >= "A" && c <= "F");
         default: dig = is_digit(c);
      endcase
      case (st)
         NS_START: begin
            if (nb == NB_DEC)
               return dig ? NS_INT : ((c == ".") ? NS_FRAC : NS_DEAD);
            return (c == "0") ? NS_ZERO : NS_DEAD;
         end
         NS_ZERO: begin
            if (nb == NB_OCT)
               return dig ? NS_INT : ((c == ".") ? NS_FRAC : NS_DEAD);
            if (nb == NB_BIN)
               return (c == "b") ? NS_PREFIX : NS_DEAD;
            if (nb == NB_HEX)
               return (c inside {"x", "X"}) ? NS_PREFIX : NS_DEAD;
            return NS_DEAD;
         end
         NS_PREFIX, NS_INT: return dig ? NS_INT : ((c == ".") ? NS_FRAC : NS_DEAD);
         NS_FRAC:           return dig ? NS_FRAC : NS_DEAD;
         default:           return NS_DEAD;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // token prediction
   // ------------------------------------------------------------------
   function void queue_token(logic [3:0] cls, logic [7:0] a, logic [7:0] b,
                             logic [3:0] kw, logic [1:0] nb, int unsigned len, logic ew);
      result_type t;
      t.token_class     = cls;
      t.first_char      = a;
      t.second_char     = b;
      t.keyword_index   = kw;
      t.number_base     = nb;
      t.word_length     = (len > 255) ? 8'd255 : 8'(len);
      t.else_without_if = ew;
      t.last_result     = 1'b0;
      item_tokens.push_back(t);
   endfunction

   function void restart_word();
      word_open  = 1'b0;
      word_len   = 0;
      kw_live    = '1;
      ident_live = 1'b1;
      foreach (num_state[i]) num_state[i] = NS_START;
   endfunction

   function void reset_lexer();
      restart_word();
      held_op       = 8'd0;
      held_op_valid = 1'b0;
      open_ifs      = '0;
   endfunction

   function void take_word_char(logic [7:0] c);
      int unsigned pos;
      pos = word_len;
      word_open = 1'b1;
      for (int k = 0; k < NUM_KW; k++) begin
         if (pos >= kw_spelling[k].len() || kw_spelling[k][pos] != c)
            kw_live[k] = 1'b0;
      end
      if (pos == 0)
         ident_live = is_letter(c) || c == "_";
      else
         ident_live = ident_live && (is_letter(c) || is_digit(c) || c == "_");
      for (int b = 0; b < NUM_BASES; b++)
         num_state[b] = next_number_state(2'(b), num_state[b], c);
      if (word_len < MAX_WORD_LEN)
         word_len++;
   endfunction

   // class the open word: keyword, then number, then identifier or unknown
   function void close_word();
      logic flag;
      if (!word_open)
         return;
      for (int k = 0; k < NUM_KW; k++) begin
         if (kw_live[k] && word_len == kw_spelling[k].len()) begin
            flag = 1'b0;
            if (k == KW_IF) begin
               if (open_ifs != '1) open_ifs++;
            end else if (k == KW_ELSE) begin
               if (open_ifs == 0) flag = 1'b1;
               else open_ifs--;
            end
            queue_token(TC_KEYWORD, 8'd0, 8'd0, 4'(k), 2'd0, word_len, flag);
            restart_word();
            return;
         end
      end
      for (int b = 0; b < NUM_BASES; b++) begin
         if (num_state[b] inside {NS_INT, NS_FRAC}) begin
            queue_token(TC_NUMBER, 8'd0, 8'd0, 4'd0, 2'(b), word_len, 1'b0);
            restart_word();
            return;
         end
      end
      queue_token(ident_live ? TC_IDENT : TC_UNKNOWN, 8'd0, 8'd0, 4'd0, 2'd0, word_len, 1'b0);
      restart_word();
   endfunction

   function void release_op();
      if (!held_op_valid)
         return;
      queue_token(TC_OP, held_op, 8'd0, 4'd0, 2'd0, 0, 1'b0);
      held_op_valid = 1'b0;
      held_op       = 8'd0;
   endfunction

   // tokens caused by one accepted item, appended to the expected list
   function void predict_tokens(logic [7:0] c, logic eot);
      item_tokens.delete();
      if (is_operator(c)) begin
         if (held_op_valid) begin
            queue_token(pair_valid(held_op, c) ? TC_PAIR : TC_BADPAIR, held_op, c,
                        4'd0, 2'd0, 0, 1'b0);
            held_op_valid = 1'b0;
            held_op       = 8'd0;
         end else begin
            close_word();
            held_op       = c;
            held_op_valid = 1'b1;
         end
      end else begin
         release_op();
         if (is_separator(c)) begin
            close_word();
            queue_token(TC_SEP, c, 8'd0, 4'd0, 2'd0, 0, 1'b0);
         end else if (c == LINE_FEED) begin
            close_word();
            queue_token(TC_EOL, 8'd0, 8'd0, 4'd0, 2'd0, 0, 1'b0);
         end else begin
            take_word_char(c);
         end
      end
      if (eot) begin
         release_op();
         close_word();
      end
      if (item_tokens.size() > 0)
         item_tokens[item_tokens.size() - 1].last_result = 1'b1;
      foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_error(input string msg);
      error_count++;
      // quiet after the first screenful, still counting
      if (error_count <= PRINT_CAP)
         $display("%0t tb_c_token_classifier mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("token %0d %s got %0h want %0h", tokens_seen, name, got, want));
   endtask

   task automatic check_token();
      result_type want;
      if (expected_tokens.size() == 0) begin
         report_error($sformatf("token %0d class %0h arrived with none pending",
                                tokens_seen, rsp_token_class));
         return;
      end
      want = expected_tokens.pop_front();
      check_field("token_class", 8'(rsp_token_class), 8'(want.token_class));
      check_field("first_char", rsp_first_char, want.first_char);
      check_field("second_char", rsp_second_char, want.second_char);
      check_field("keyword_index", 8'(rsp_keyword_index), 8'(want.keyword_index));
      check_field("number_base", 8'(rsp_number_base), 8'(want.number_base));
      check_field("word_length", rsp_word_length, want.word_length);
      check_field("else_without_if", 8'(rsp_else_without_if), 8'(want.else_without_if));
      check_field("last_result", 8'(rsp_last_result), 8'(want.last_result));
   endtask

   // sample both handshakes at each edge; predict first, then check
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            predict_tokens(req_ch, req_end_of_text);
         if (rsp_pop && !rsp_empty) begin
            check_token();
            tokens_seen++;
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_c_token_classifier: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic random_eot();
      return $urandom_range(99) < eot_pct;
   endfunction

   function automatic logic [7:0] rand_name_char(bit lead);
      int r;
      r = $urandom_range(lead ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] rand_digit(logic [1:0] nb);
      int r;
      case (nb)
         NB_BIN: return 8'("0" + $urandom_range(1));
         NB_OCT: return 8'("0" + $urandom_range(7));
         NB_HEX: begin
            r = $urandom_range(15);
            return (r < 10) ? 8'("0" + r) : 8'("A" + r - 10);
         end
         default: return 8'("0" + $urandom_range(9));
      endcase
   endfunction

   // one item; push stays high from item to item unless the sender idles
   task automatic send_char(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_ch          <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], random_eot());
   endtask

   // hold the sender off until every predicted token has been popped
   task automatic wait_for_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   // what usually follows a word in source text
   task automatic send_word_end();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         send_char(sep_chars[$urandom_range(8)], random_eot());
      else if (r < 75)
         send_char(LINE_FEED, random_eot());
      else if (r < 90)
         send_char(op_chars[$urandom_range(8)], random_eot());
   endtask

   task automatic send_random_token();
      int         pick;
      int         n;
      int         k;
      logic [1:0] nb;
      pick = $urandom_range(99);
      if (pick < 20) begin
         // keywords, if and else favored so the depth moves both ways
         if ($urandom_range(1))
            k = $urandom_range(1) ? int'(KW_IF) : int'(KW_ELSE);
         else
            k = $urandom_range(NUM_KW - 1);
         send_string(kw_spelling[k]);
         if ($urandom_range(9) == 0)
            send_char(rand_name_char(1'b0), random_eot());
         send_word_end();
      end else if (pick < 38) begin
         n = $urandom_range(7);
         send_char(rand_name_char(1'b1), random_eot());
         repeat (n) send_char(rand_name_char(1'b0), random_eot());
         send_word_end();
      end else if (pick < 55) begin
         nb = 2'($urandom_range(3));
         case (nb)
            NB_BIN:  send_string("0b");
            NB_OCT:  send_char("0", random_eot());
            NB_HEX:  send_string($urandom_range(1) ? "0x" : "0X");
            default: ;
         endcase
         n = $urandom_range(5);
         repeat (n) send_char(rand_digit(nb), random_eot());
         if ($urandom_range(9) < 3) begin
            send_char(".", random_eot());
            n = $urandom_range(3);
            repeat (n) send_char(rand_digit(nb), random_eot());
         end
         // occasionally spoil the number with a stray printable byte
         if ($urandom_range(9) == 0)
            send_char(8'($urandom_range(126, 33)), random_eot());
         send_word_end();
      end else if (pick < 70) begin
         if ($urandom_range(1)) begin
            k = $urandom_range(10);
            send_char(good_pairs[2 * k], random_eot());
            send_char(good_pairs[2 * k + 1], random_eot());
         end else begin
            n = $urandom_range(3, 1);
            repeat (n) send_char(op_chars[$urandom_range(8)], random_eot());
         end
      end else if (pick < 82) begin
         send_char(sep_chars[$urandom_range(8)], random_eot());
      end else if (pick < 90) begin
         send_char(LINE_FEED, random_eot());
      end else begin
         n = $urandom_range(4, 1);
         repeat (n) send_char(8'($urandom_range(255)), random_eot());
      end
   endtask

   task automatic random_stream(input int count);
      int start;
      start = chars_sent;
      eot_pct = 4;
      while (chars_sent - start < count) send_random_token();
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // every token class, byte extremes, depth flag, lone dot, operator run,
   // newline and end-of-text flushes
   task automatic test_directed();
      eot_pct = 0;
      send_string("else ");
      send_string("if(");
      send_string("0b.++=");
      send_char(8'hFF, 1'b0);
      send_string("!<");
      send_string(".");
      send_char(LINE_FEED, 1'b0);
      send_string("x_");
      send_char("9", 1'b1);
      send_char("}", 1'b0);
      send_char(8'h00, 1'b1);
   endtask

   // word length saturates
   task automatic test_long_word();
      eot_pct = 0;
      send_char("a", 1'b0);
      repeat (299) send_char(rand_name_char(1'b0), 1'b0);
      send_char(" ", 1'b0);
   endtask

   task automatic test_stream_receiver_stalls();
      send_idle_pct = 21;
      recv_idle_pct = 46;
      random_stream(140);
   endtask

   task automatic test_stream_sender_gaps();
      send_idle_pct = 46;
      recv_idle_pct = 21;
      random_stream(140);
   endtask

   task automatic test_stream_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_stream(140);
   endtask

   initial begin
      reset_lexer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_word();
      wait_for_drain();
      test_stream_receiver_stalls();
      wait_for_drain();
      test_stream_sender_gaps();
      test_stream_full_rate();

      // drain, then give stray tokens a chance to show up
      req_push <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_c_token_classifier: clean");
      else
         $display("tb_c_token_classifier: errors");
      $finish;
   end

endmodule
